/* rtl/abfg_pkg.sv */
// Shared types, constants and microcode program of the battery fuel gauge.
package abfg_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned ScaleW     = 16;
  localparam int unsigned DesignW    = 25;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = DesignW;

  localparam int unsigned MulAW      = 24;
  localparam int unsigned MulBW      = 16;
  localparam int unsigned MulPW      = MulAW + MulBW;
  localparam int unsigned DivW       = 40;
  localparam int unsigned DsrW       = 16;
  localparam int unsigned DivStepsW  = 5;
  localparam int unsigned PcW        = 5;

  // two quotient bits per divider cycle
  localparam logic [DivStepsW-1:0] StepsFull = DivStepsW'(DivW / 2);
  localparam logic [DivStepsW-1:0] Steps32   = DivStepsW'(32 / 2);
  localparam logic [DivStepsW-1:0] StepsCfg  = DivStepsW'((DesignW + 1) / 2);

  localparam logic [ScaleW-1:0] Milli = ScaleW'(1000);
  // smallest quotient whose value in micro units leaves the signed 32-bit range
  localparam logic [DivW-1:0]   SatQ  = DivW'(2147484);

  localparam logic [CfgIdxW-1:0] CfgVoltageScale     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCurrentScale     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTemperatureScale = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDesignVoltageMax = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDesignVoltageMin = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDesignChargeFull = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDesignChargeEmpty = 3'd6;

  localparam logic [1:0] StatusCharging    = 2'd0;
  localparam logic [1:0] StatusFull        = 2'd1;
  localparam logic [1:0] StatusDischarging = 2'd2;
  localparam logic [1:0] ChargerOff        = 2'd0;

  typedef struct packed {
    logic [SampleBits-1:0] voltage_sample;
    logic [SampleBits-1:0] current_sample;
    logic [SampleBits-1:0] temperature_sample;
    logic                  external_power;
    logic [1:0]            charger_state;
  } in_t;

  typedef struct packed {
    logic [1:0]         batt_status;
    logic [31:0]        voltage_now;
    logic [31:0]        current_now;
    logic signed [31:0] charge_now;
    logic [22:0]        temperature_now;
    logic               divide_fault;
    logic               sample_accepted;
  } out_t;

  typedef struct packed {
    logic [ScaleW-1:0]  voltage_scale;
    logic [ScaleW-1:0]  current_scale;
    logic [ScaleW-1:0]  temperature_scale;
    logic [DesignW-1:0] design_voltage_max;
    logic [DesignW-1:0] design_voltage_min;
    logic [DesignW-1:0] design_charge_full;
    logic [DesignW-1:0] design_charge_empty;
  } cfg_t;

  typedef struct packed {
    logic [SampleBits-1:0] voltage;
    logic [SampleBits-1:0] current;
    logic [SampleBits-1:0] temperature;
  } samp_t;

  typedef struct packed {
    logic [31:0]        voltage_now;
    logic [31:0]        current_now;
    logic signed [31:0] charge_now;
    logic [22:0]        temperature_now;
    logic               divide_fault;
  } res_t;

  typedef enum logic [4:0] {
    U_NOP,
    U_MUL_V,
    U_WR_VNOW,
    U_MUL_I,
    U_WR_INOW,
    U_MUL_T,
    U_DIV_PROD,
    U_WR_TNOW,
    U_DIV_VNOW,
    U_WR_MV,
    U_DIV_VMAX,
    U_WR_A,
    U_DIV_VMIN,
    U_WIN_DIFF,
    U_DIV_FULL,
    U_DIV_EMPTY,
    U_CWIN,
    U_MUL_NUM,
    U_DIV_NUM,
    U_MUL_CHG,
    U_WR_CHG,
    U_FAULT,
    U_FINISH
  } uop_e;

  typedef enum logic [1:0] {
    J_NONE,
    J_WIN_ZERO,
    J_ALWAYS
  } jmp_e;

  typedef struct packed {
    uop_e           uop;
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    uop_e uop;
    logic exec;
    logic div_start;
  } seq_ctrl_t;

  typedef struct packed {
    logic win_zero;
    logic div_done;
  } dp_stat_t;

  localparam logic [PcW-1:0] PcFault  = 5'd22;
  localparam logic [PcW-1:0] PcFinish = 5'd23;

  function automatic ucode_t ucode(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:    w = '{U_MUL_V,     J_NONE,     '0};
      5'd1:    w = '{U_WR_VNOW,   J_NONE,     '0};
      5'd2:    w = '{U_MUL_I,     J_NONE,     '0};
      5'd3:    w = '{U_WR_INOW,   J_NONE,     '0};
      5'd4:    w = '{U_MUL_T,     J_NONE,     '0};
      5'd5:    w = '{U_DIV_PROD,  J_NONE,     '0};
      5'd6:    w = '{U_WR_TNOW,   J_NONE,     '0};
      5'd7:    w = '{U_DIV_VNOW,  J_NONE,     '0};
      5'd8:    w = '{U_WR_MV,     J_NONE,     '0};
      5'd9:    w = '{U_DIV_VMAX,  J_NONE,     '0};
      5'd10:   w = '{U_WR_A,      J_NONE,     '0};
      5'd11:   w = '{U_DIV_VMIN,  J_NONE,     '0};
      5'd12:   w = '{U_WIN_DIFF,  J_NONE,     '0};
      5'd13:   w = '{U_NOP,       J_WIN_ZERO, PcFault};
      5'd14:   w = '{U_DIV_FULL,  J_NONE,     '0};
      5'd15:   w = '{U_WR_A,      J_NONE,     '0};
      5'd16:   w = '{U_DIV_EMPTY, J_NONE,     '0};
      5'd17:   w = '{U_CWIN,      J_NONE,     '0};
      5'd18:   w = '{U_MUL_NUM,   J_NONE,     '0};
      5'd19:   w = '{U_DIV_NUM,   J_NONE,     '0};
      5'd20:   w = '{U_MUL_CHG,   J_NONE,     '0};
      5'd21:   w = '{U_WR_CHG,    J_ALWAYS,   PcFinish};
      5'd22:   w = '{U_FAULT,     J_NONE,     '0};
      5'd23:   w = '{U_FINISH,    J_NONE,     '0};
      default: w = '{U_FINISH,    J_NONE,     '0};
    endcase
    return w;
  endfunction

endpackage

/* rtl/abfg_div.sv */
// Iterative unsigned restoring divider, two quotient bits per cycle.
module abfg_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [abfg_pkg::DivW-1:0]            dividend_i,
  input  logic [abfg_pkg::DsrW-1:0]            divisor_i,
  input  logic [abfg_pkg::DivStepsW-1:0]       steps_i,
  output logic                                 done_o,
  output logic [abfg_pkg::DivW-1:0]            quotient_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [abfg_pkg::DivStepsW-1:0]    cnt_q;
  logic [abfg_pkg::DsrW-1:0]         rem_q;
  logic [abfg_pkg::DsrW-1:0]         dsr_q;
  logic [abfg_pkg::DivW-1:0]         dq_q;

  logic [abfg_pkg::DsrW:0]   r1, r2;
  logic                      ge1, ge2;
  logic [abfg_pkg::DsrW-1:0] rem1, rem2;
  logic [abfg_pkg::DivW-1:0] dq1, dq2;

  // dividend is left-aligned in dq; quotient bits shift in from the right
  always_comb begin
    r1   = {rem_q, dq_q[abfg_pkg::DivW-1]};
    ge1  = r1 >= {1'b0, dsr_q};
    rem1 = ge1 ? abfg_pkg::DsrW'(r1 - {1'b0, dsr_q}) : r1[abfg_pkg::DsrW-1:0];
    dq1  = {dq_q[abfg_pkg::DivW-2:0], ge1};
    r2   = {rem1, dq1[abfg_pkg::DivW-1]};
    ge2  = r2 >= {1'b0, dsr_q};
    rem2 = ge2 ? abfg_pkg::DsrW'(r2 - {1'b0, dsr_q}) : r2[abfg_pkg::DsrW-1:0];
    dq2  = {dq1[abfg_pkg::DivW-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - abfg_pkg::DivStepsW'(1);
        if (cnt_q == abfg_pkg::DivStepsW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      dq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem2;
      dq_q  <= dq2;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

/* rtl/abfg_seq.sv */
// Microcode sequencer: step counter, program fetch, divider waits and jumps.
module abfg_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 out_free_i,
  input  abfg_pkg::dp_stat_t   stat_i,
  output abfg_pkg::seq_ctrl_t  ctrl_o,
  output logic                 busy_o,
  output logic                 done_o
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e                    state_q;
  logic [abfg_pkg::PcW-1:0]  pc_q;
  logic                      wait_q;

  abfg_pkg::ucode_t          cw;
  logic                      is_div;
  logic                      advance;
  logic                      take_jump;
  logic [abfg_pkg::PcW-1:0]  pc_next;

  always_comb begin
    cw     = abfg_pkg::ucode(pc_q);
    is_div = cw.uop inside {abfg_pkg::U_DIV_PROD, abfg_pkg::U_DIV_VNOW,
                            abfg_pkg::U_DIV_VMAX, abfg_pkg::U_DIV_VMIN,
                            abfg_pkg::U_DIV_FULL, abfg_pkg::U_DIV_EMPTY,
                            abfg_pkg::U_DIV_NUM};
    ctrl_o.uop       = cw.uop;
    ctrl_o.exec      = 1'b0;
    ctrl_o.div_start = 1'b0;
    advance          = 1'b0;
    done_o           = 1'b0;
    if (state_q == S_RUN) begin
      if (is_div) begin
        if (!wait_q) begin
          ctrl_o.div_start = 1'b1;
        end else if (stat_i.div_done) begin
          advance = 1'b1;
        end
      end else if (cw.uop == abfg_pkg::U_FINISH) begin
        done_o = out_free_i;
      end else begin
        ctrl_o.exec = 1'b1;
        advance     = 1'b1;
      end
    end
    take_jump = (cw.jmp == abfg_pkg::J_ALWAYS) ||
                ((cw.jmp == abfg_pkg::J_WIN_ZERO) && stat_i.win_zero);
    pc_next   = take_jump ? cw.target : pc_q + abfg_pkg::PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      wait_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_RUN;
            pc_q    <= '0;
            wait_q  <= 1'b0;
          end
        end
        S_RUN: begin
          if (ctrl_o.div_start) begin
            wait_q <= 1'b1;
          end
          if (advance) begin
            pc_q   <= pc_next;
            wait_q <= 1'b0;
          end
          if (done_o) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = state_q == S_RUN;

endmodule

/* rtl/abfg_dp.sv */
// Datapath: shared multiplier, shared divider and the working registers.
module abfg_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  abfg_pkg::seq_ctrl_t  ctrl_i,
  input  abfg_pkg::cfg_t       cfg_i,
  input  abfg_pkg::samp_t      good_i,
  output abfg_pkg::dp_stat_t   stat_o,
  output abfg_pkg::res_t       res_o
);

  logic [abfg_pkg::MulAW-1:0]     mul_a;
  logic [abfg_pkg::MulBW-1:0]     mul_b;
  logic [abfg_pkg::MulPW-1:0]     mul_p;
  logic [abfg_pkg::DivW-1:0]      div_dvd;
  logic [abfg_pkg::DsrW-1:0]      div_dsr;
  logic [abfg_pkg::DivStepsW-1:0] div_steps;
  logic                           div_done;
  logic [abfg_pkg::DivW-1:0]      quo;

  logic [abfg_pkg::MulPW-1:0]     p_q;
  logic [31:0]                    vnow_q;
  logic [31:0]                    inow_q;
  logic [22:0]                    tnow_q;
  logic [22:0]                    mv_q;
  logic [15:0]                    a_q;
  logic [15:0]                    win_mag_q;
  logic                           win_neg_q;
  logic [abfg_pkg::MulAW-1:0]     diff_mag_q;
  logic                           diff_neg_q;
  logic [15:0]                    cwin_mag_q;
  logic                           cwin_neg_q;
  logic signed [31:0]             charge_q;
  logic                           fault_q;

  logic [abfg_pkg::ScaleW-1:0]    vs_eff, cs_eff, ts_eff;
  logic [15:0]                    qv;
  logic                           a_lt;
  logic [15:0]                    a_diff;
  logic [abfg_pkg::MulAW-1:0]     mv_ext, qv_ext, mv_diff;
  logic                           mv_lt;
  logic                           q_neg;
  logic                           q_sat;

  // a zero scale register means 1000
  assign vs_eff = (cfg_i.voltage_scale == '0) ? abfg_pkg::Milli : cfg_i.voltage_scale;
  assign cs_eff = (cfg_i.current_scale == '0) ? abfg_pkg::Milli : cfg_i.current_scale;
  assign ts_eff = (cfg_i.temperature_scale == '0) ? abfg_pkg::Milli
                                                    : cfg_i.temperature_scale;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.uop)
      abfg_pkg::U_MUL_V: begin
        mul_a = abfg_pkg::MulAW'(good_i.voltage);
        mul_b = vs_eff;
      end
      abfg_pkg::U_MUL_I: begin
        mul_a = abfg_pkg::MulAW'(good_i.current);
        mul_b = cs_eff;
      end
      abfg_pkg::U_MUL_T: begin
        mul_a = abfg_pkg::MulAW'(good_i.temperature);
        mul_b = ts_eff;
      end
      abfg_pkg::U_MUL_NUM: begin
        mul_a = diff_mag_q;
        mul_b = cwin_mag_q;
      end
      abfg_pkg::U_MUL_CHG: begin
        mul_a = quo[abfg_pkg::MulAW-1:0];
        mul_b = abfg_pkg::Milli;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{abfg_pkg::MulBW{1'b0}}, mul_a} * {{abfg_pkg::MulAW{1'b0}}, mul_b};

  // operands are left-aligned so the quotient lands in the low bits
  always_comb begin
    div_dvd   = p_q;
    div_dsr   = abfg_pkg::Milli;
    div_steps = abfg_pkg::StepsFull;
    case (ctrl_i.uop)
      abfg_pkg::U_DIV_PROD: begin
        div_dvd   = p_q;
        div_steps = abfg_pkg::StepsFull;
      end
      abfg_pkg::U_DIV_VNOW: begin
        div_dvd   = {vnow_q, 8'd0};
        div_steps = abfg_pkg::Steps32;
      end
      abfg_pkg::U_DIV_VMAX: begin
        div_dvd   = {1'b0, cfg_i.design_voltage_max, 14'd0};
        div_steps = abfg_pkg::StepsCfg;
      end
      abfg_pkg::U_DIV_VMIN: begin
        div_dvd   = {1'b0, cfg_i.design_voltage_min, 14'd0};
        div_steps = abfg_pkg::StepsCfg;
      end
      abfg_pkg::U_DIV_FULL: begin
        div_dvd   = {1'b0, cfg_i.design_charge_full, 14'd0};
        div_steps = abfg_pkg::StepsCfg;
      end
      abfg_pkg::U_DIV_EMPTY: begin
        div_dvd   = {1'b0, cfg_i.design_charge_empty, 14'd0};
        div_steps = abfg_pkg::StepsCfg;
      end
      abfg_pkg::U_DIV_NUM: begin
        div_dvd   = p_q;
        div_dsr   = win_mag_q;
        div_steps = abfg_pkg::StepsFull;
      end
      default: begin
        div_dvd   = p_q;
        div_steps = abfg_pkg::StepsFull;
      end
    endcase
  end

  abfg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // sign and magnitude of the window differences, taken from the last quotient
  always_comb begin
    qv      = quo[15:0];
    a_lt    = a_q < qv;
    a_diff  = a_lt ? qv - a_q : a_q - qv;
    mv_ext  = abfg_pkg::MulAW'(mv_q);
    qv_ext  = abfg_pkg::MulAW'(qv);
    mv_lt   = mv_ext < qv_ext;
    mv_diff = mv_lt ? qv_ext - mv_ext : mv_ext - qv_ext;
    q_neg   = diff_neg_q ^ cwin_neg_q ^ win_neg_q;
    q_sat   = quo >= abfg_pkg::SatQ;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      case (ctrl_i.uop)
        abfg_pkg::U_MUL_V,
        abfg_pkg::U_MUL_I,
        abfg_pkg::U_MUL_T,
        abfg_pkg::U_MUL_NUM,
        abfg_pkg::U_MUL_CHG: p_q <= mul_p;
        abfg_pkg::U_WR_VNOW: vnow_q <= p_q[31:0];
        abfg_pkg::U_WR_INOW: inow_q <= p_q[31:0];
        abfg_pkg::U_WR_TNOW: tnow_q <= quo[22:0];
        abfg_pkg::U_WR_MV:   mv_q   <= quo[22:0];
        abfg_pkg::U_WR_A:    a_q    <= quo[15:0];
        abfg_pkg::U_WIN_DIFF: begin
          win_neg_q  <= a_lt;
          win_mag_q  <= a_diff;
          diff_neg_q <= mv_lt;
          diff_mag_q <= mv_diff;
        end
        abfg_pkg::U_CWIN: begin
          cwin_neg_q <= a_lt;
          cwin_mag_q <= a_diff;
        end
        abfg_pkg::U_WR_CHG: begin
          fault_q <= 1'b0;
          if (q_sat) begin
            charge_q <= q_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            charge_q <= q_neg ? -p_q[31:0] : p_q[31:0];
          end
        end
        abfg_pkg::U_FAULT: begin
          fault_q  <= 1'b1;
          charge_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.win_zero = win_mag_q == '0;
  assign stat_o.div_done = div_done;

  assign res_o.voltage_now     = vnow_q;
  assign res_o.current_now     = inow_q;
  assign res_o.charge_now      = charge_q;
  assign res_o.temperature_now = tnow_q;
  assign res_o.divide_fault    = fault_q;

endmodule

/* rtl/adc_battery_fuel_gauge.sv */
// Top level of the linear-voltage battery fuel gauge.
//
// Input channel: one request carries a raw voltage, current and temperature
// sample set plus the external-power and charger flags. A nonzero voltage
// sample replaces the stored sample set; the charge status comes from the flags.
// Output channel: one result per request with all properties at once.
// Configuration: write enable, register index and data; write only while idle.
// Timing: the request is computed by a microcoded sequencer driving one shared
// multiplier and one shared divider that yields two quotient bits per cycle.
// The divisions (seven, or four when the design voltage window is zero) take
// most of the time from acceptance to a valid result. One request is in work
// at a time, so a new one can start only once the last is done; in_stall_o is
// high while it runs. The result waits in an output register; the next
// request is accepted while it waits. If the receiver stalls, a finished
// computation holds in its last step until the output register frees up.
// Reset clears the stored samples, sets the scales to 1000 and the design
// window registers to zero.
module adc_battery_fuel_gauge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  abfg_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output abfg_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [abfg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [abfg_pkg::CfgDataW-1:0] cfg_wdata_i
);

  abfg_pkg::cfg_t      cfg_q;
  abfg_pkg::samp_t     good_q;
  logic [1:0]          status_q;
  logic                accepted_q;
  abfg_pkg::out_t      out_q;
  logic                out_valid_q;

  abfg_pkg::seq_ctrl_t ctrl;
  abfg_pkg::dp_stat_t  stat;
  abfg_pkg::res_t      res;
  logic                busy;
  logic                done;
  logic                in_accept;
  logic                out_free;
  logic [1:0]          status_d;

  assign in_accept = in_valid_i && !busy;
  assign out_free  = !out_valid_q || !out_stall_i;

  // unknown charger state counts as charging
  always_comb begin
    if (in_data_i.external_power && (in_data_i.charger_state != abfg_pkg::ChargerOff)) begin
      status_d = abfg_pkg::StatusCharging;
    end else if (in_data_i.external_power) begin
      status_d = abfg_pkg::StatusFull;
    end else begin
      status_d = abfg_pkg::StatusDischarging;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage_scale       <= abfg_pkg::Milli;
      cfg_q.current_scale       <= abfg_pkg::Milli;
      cfg_q.temperature_scale   <= abfg_pkg::Milli;
      cfg_q.design_voltage_max  <= '0;
      cfg_q.design_voltage_min  <= '0;
      cfg_q.design_charge_full  <= '0;
      cfg_q.design_charge_empty <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        abfg_pkg::CfgVoltageScale:
          cfg_q.voltage_scale <= cfg_wdata_i[abfg_pkg::ScaleW-1:0];
        abfg_pkg::CfgCurrentScale:
          cfg_q.current_scale <= cfg_wdata_i[abfg_pkg::ScaleW-1:0];
        abfg_pkg::CfgTemperatureScale:
          cfg_q.temperature_scale <= cfg_wdata_i[abfg_pkg::ScaleW-1:0];
        abfg_pkg::CfgDesignVoltageMax:
          cfg_q.design_voltage_max <= cfg_wdata_i[abfg_pkg::DesignW-1:0];
        abfg_pkg::CfgDesignVoltageMin:
          cfg_q.design_voltage_min <= cfg_wdata_i[abfg_pkg::DesignW-1:0];
        abfg_pkg::CfgDesignChargeFull:
          cfg_q.design_charge_full <= cfg_wdata_i[abfg_pkg::DesignW-1:0];
        abfg_pkg::CfgDesignChargeEmpty:
          cfg_q.design_charge_empty <= cfg_wdata_i[abfg_pkg::DesignW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept && (in_data_i.voltage_sample != '0)) begin
        good_q.voltage     <= in_data_i.voltage_sample;
        good_q.current     <= in_data_i.current_sample;
        good_q.temperature <= in_data_i.temperature_sample;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q   <= status_d;
      accepted_q <= in_data_i.voltage_sample != '0;
    end
    if (done) begin
      out_q.batt_status     <= status_q;
      out_q.voltage_now     <= res.voltage_now;
      out_q.current_now     <= res.current_now;
      out_q.charge_now      <= res.charge_now;
      out_q.temperature_now <= res.temperature_now;
      out_q.divide_fault    <= res.divide_fault;
      out_q.sample_accepted <= accepted_q;
    end
  end

  abfg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .done_o     (done)
  );

  abfg_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg_q),
    .good_i (good_q),
    .stat_o (stat),
    .res_o  (res)
  );

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/sv/adc_battery_fuel_gauge_tb.sv */
// Self-checking testbench of the battery fuel gauge: bursty request driver, stalling monitor.
`timescale 1ns / 1ps

module adc_battery_fuel_gauge_tb;

  localparam longint Milli64 = 1000;
  localparam logic signed [31:0] ChargeTop    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ChargeBottom = 32'sh8000_0000;
  localparam logic [1:0] ChargerOn        = 2'd1;
  localparam logic [1:0] ChargerUnknown   = 2'd2;
  localparam logic [1:0] ChargerUndefined = 2'd3;
  localparam int unsigned RandomPerSetting = 117;
  localparam int unsigned LongHold = 600;
  localparam int unsigned TailCycles = 160;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  abfg_pkg::in_t                   in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  abfg_pkg::out_t                  out_data_o;
  logic                            cfg_we_i    = 1'b0;
  logic [abfg_pkg::CfgIdxW-1:0]    cfg_idx_i   = '0;
  logic [abfg_pkg::CfgDataW-1:0]   cfg_wdata_i = '0;

  // predictor state: register file copy and last good sample set
  abfg_pkg::cfg_t                  gauge_cfg;
  logic [abfg_pkg::SampleBits-1:0] good_volt = '0;
  logic [abfg_pkg::SampleBits-1:0] good_amp  = '0;
  logic [abfg_pkg::SampleBits-1:0] good_temp = '0;

  abfg_pkg::in_t  sample_q[$];
  abfg_pkg::out_t readings_due[$];

  int unsigned mismatches    = 0;
  int unsigned readings_seen = 0;
  int unsigned samples_sent  = 0;
  int unsigned invalid_sets  = 0;
  int unsigned fault_cnt     = 0;
  int unsigned sat_cnt       = 0;
  int unsigned settings_cnt  = 0;
  int unsigned holds_done    = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  int unsigned rx_cycle   = 0;
  rx_mode_e    rx_mode    = RX_OPEN;

  adc_battery_fuel_gauge dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic abfg_pkg::out_t compute_reading(abfg_pkg::in_t s);
    abfg_pkg::out_t r;
    longint unsigned vsc, isc, tsc, prod;
    longint mv, vmax_mv, vmin_mv, full_mah, empty_mah, win, span, num, q, chg;
    r = '0;
    if (s.external_power && s.charger_state != abfg_pkg::ChargerOff) begin
      r.batt_status = abfg_pkg::StatusCharging;
    end else if (s.external_power) begin
      r.batt_status = abfg_pkg::StatusFull;
    end else begin
      r.batt_status = abfg_pkg::StatusDischarging;
    end
    r.sample_accepted = (s.voltage_sample != '0);
    if (r.sample_accepted) begin
      good_volt = s.voltage_sample;
      good_amp  = s.current_sample;
      good_temp = s.temperature_sample;
    end
    vsc = (gauge_cfg.voltage_scale == '0) ? Milli64 : gauge_cfg.voltage_scale;
    isc = (gauge_cfg.current_scale == '0) ? Milli64 : gauge_cfg.current_scale;
    tsc = (gauge_cfg.temperature_scale == '0) ? Milli64 : gauge_cfg.temperature_scale;
    prod = good_volt * vsc;
    r.voltage_now = prod[31:0];
    prod = good_amp * isc;
    r.current_now = prod[31:0];
    prod = (good_temp * tsc) / Milli64;
    r.temperature_now = prod[22:0];

    vmax_mv   = gauge_cfg.design_voltage_max / Milli64;
    vmin_mv   = gauge_cfg.design_voltage_min / Milli64;
    full_mah  = gauge_cfg.design_charge_full / Milli64;
    empty_mah = gauge_cfg.design_charge_empty / Milli64;
    win  = vmax_mv - vmin_mv;
    span = full_mah - empty_mah;
    if (win == 0) begin
      r.divide_fault = 1'b1;
      r.charge_now   = '0;
    end else begin
      mv  = r.voltage_now / Milli64;
      num = (mv - vmin_mv) * span;
      q   = num / win;  // truncates toward zero
      chg = q * Milli64;
      if (chg > ChargeTop) chg = ChargeTop;
      if (chg < ChargeBottom) chg = ChargeBottom;
      r.charge_now = chg[31:0];
    end
    return r;
  endfunction

  function automatic abfg_pkg::in_t make_sample(logic [abfg_pkg::SampleBits-1:0] v,
                                                logic [abfg_pkg::SampleBits-1:0] c,
                                                logic [abfg_pkg::SampleBits-1:0] t,
                                                logic ext, logic [1:0] chg);
    abfg_pkg::in_t s;
    s.voltage_sample     = v;
    s.current_sample     = c;
    s.temperature_sample = t;
    s.external_power     = ext;
    s.charger_state      = chg;
    return s;
  endfunction

  function automatic logic [abfg_pkg::SampleBits-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return abfg_pkg::SampleBits'(1);
      2:       return abfg_pkg::SampleBits'($urandom_range(0, 255));
      default: return abfg_pkg::SampleBits'($urandom);
    endcase
  endfunction

  function automatic abfg_pkg::in_t random_sample();
    abfg_pkg::in_t s;
    longint unsigned lo, hi, tmp, target, raw, eff_v;
    s = make_sample('0, pick_raw(), pick_raw(), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)));
    case ($urandom_range(0, 7))
      0: s.voltage_sample = '0;
      1, 2, 3: begin
        // aim at the design window so the interpolation is exercised
        lo = gauge_cfg.design_voltage_min;
        hi = gauge_cfg.design_voltage_max;
        if (lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        eff_v  = (gauge_cfg.voltage_scale == '0) ? Milli64 : gauge_cfg.voltage_scale;
        target = lo + ($urandom % (hi - lo + 1));
        raw    = target / eff_v;
        s.voltage_sample = (raw > 65535) ? '1 : abfg_pkg::SampleBits'(raw);
      end
      default: s.voltage_sample = pick_raw();
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_reading(abfg_pkg::out_t got, abfg_pkg::out_t want);
    if (got.batt_status !== want.batt_status)
      report_mismatch($sformatf("reading %0d batt_status got %0d want %0d",
                                readings_seen, got.batt_status, want.batt_status));
    if (got.voltage_now !== want.voltage_now)
      report_mismatch($sformatf("reading %0d voltage_now got %0d want %0d",
                                readings_seen, got.voltage_now, want.voltage_now));
    if (got.current_now !== want.current_now)
      report_mismatch($sformatf("reading %0d current_now got %0d want %0d",
                                readings_seen, got.current_now, want.current_now));
    if (got.charge_now !== want.charge_now)
      report_mismatch($sformatf("reading %0d charge_now got %0d want %0d",
                                readings_seen, got.charge_now, want.charge_now));
    if (got.temperature_now !== want.temperature_now)
      report_mismatch($sformatf("reading %0d temperature_now got %0d want %0d",
                                readings_seen, got.temperature_now, want.temperature_now));
    if (got.divide_fault !== want.divide_fault)
      report_mismatch($sformatf("reading %0d divide_fault got %0d want %0d",
                                readings_seen, got.divide_fault, want.divide_fault));
    if (got.sample_accepted !== want.sample_accepted)
      report_mismatch($sformatf("reading %0d sample_accepted got %0d want %0d",
                                readings_seen, got.sample_accepted, want.sample_accepted));
  endtask

  task automatic write_reg(logic [abfg_pkg::CfgIdxW-1:0] idx,
                           logic [abfg_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      abfg_pkg::CfgVoltageScale:
        gauge_cfg.voltage_scale       = val[abfg_pkg::ScaleW-1:0];
      abfg_pkg::CfgCurrentScale:
        gauge_cfg.current_scale       = val[abfg_pkg::ScaleW-1:0];
      abfg_pkg::CfgTemperatureScale:
        gauge_cfg.temperature_scale   = val[abfg_pkg::ScaleW-1:0];
      abfg_pkg::CfgDesignVoltageMax:  gauge_cfg.design_voltage_max  = val;
      abfg_pkg::CfgDesignVoltageMin:  gauge_cfg.design_voltage_min  = val;
      abfg_pkg::CfgDesignChargeFull:  gauge_cfg.design_charge_full  = val;
      abfg_pkg::CfgDesignChargeEmpty: gauge_cfg.design_charge_empty = val;
      default: ;
    endcase
  endtask

  // only called while nothing is in flight
  task automatic program_gauge(logic [abfg_pkg::CfgDataW-1:0] vs,
                               logic [abfg_pkg::CfgDataW-1:0] cs,
                               logic [abfg_pkg::CfgDataW-1:0] ts,
                               logic [abfg_pkg::CfgDataW-1:0] vmax,
                               logic [abfg_pkg::CfgDataW-1:0] vmin,
                               logic [abfg_pkg::CfgDataW-1:0] full,
                               logic [abfg_pkg::CfgDataW-1:0] empty);
    write_reg(abfg_pkg::CfgVoltageScale, vs);
    write_reg(abfg_pkg::CfgCurrentScale, cs);
    write_reg(abfg_pkg::CfgTemperatureScale, ts);
    write_reg(abfg_pkg::CfgDesignVoltageMax, vmax);
    write_reg(abfg_pkg::CfgDesignVoltageMin, vmin);
    write_reg(abfg_pkg::CfgDesignChargeFull, full);
    write_reg(abfg_pkg::CfgDesignChargeEmpty, empty);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || readings_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) sample_q.push_back(random_sample());
    drain();
  endtask

  // request driver: bursts of back-to-back requests separated by random gaps
  always @(posedge clk_i) begin : drive_samples
    abfg_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = compute_reading(in_data_i);
        readings_due.push_back(want);
        void'(sample_q.pop_front());
        samples_sent++;
        if (!want.sample_accepted) invalid_sets++;
        if (want.divide_fault) fault_cnt++;
        if (want.charge_now == ChargeTop || want.charge_now == ChargeBottom) sat_cnt++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sample_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  always @(posedge clk_i) begin : watch_readings
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        readings_seen++;
        if (readings_due.size() == 0) begin
          report_mismatch($sformatf("reading %0d arrived with no request pending",
                                    readings_seen));
        end else begin
          check_reading(out_data_o, readings_due.pop_front());
        end
        // long hold-off lets the block back up into its input
        if (readings_seen == 150 || readings_seen == 700) begin
          hold_left = LongHold;
          holds_done++;
        end
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:  out_stall_i <= 1'b0;
          RX_COIN:  out_stall_i <= 1'($urandom_range(0, 1));
          RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:  out_stall_i <= ((rx_cycle % 7) < 3);
        endcase
      end
    end
  end

  initial begin
    gauge_cfg = '0;
    gauge_cfg.voltage_scale     = abfg_pkg::ScaleW'(1000);
    gauge_cfg.current_scale     = abfg_pkg::ScaleW'(1000);
    gauge_cfg.temperature_scale = abfg_pkg::ScaleW'(1000);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: zero window, stored set still clear
    sample_q.push_back(make_sample('0, 16'h1234, 16'h4321, 1'b0, abfg_pkg::ChargerOff));
    sample_q.push_back(make_sample('1, '1, '1, 1'b1, ChargerUndefined));
    sample_q.push_back(make_sample('0, '0, '0, 1'b1, abfg_pkg::ChargerOff));
    drain();

    program_gauge(25'd1000, 25'd1000, 25'd1000, 25'd4200000, 25'd3000000, 25'd2000000,
                  25'd0);
    sample_q.push_back(make_sample(16'd1, '0, '0, 1'b0, abfg_pkg::ChargerOff));
    sample_q.push_back(make_sample('1, '1, '1, 1'b1, ChargerOn));
    sample_q.push_back(make_sample('0, 16'h1234, 16'h4321, 1'b1, abfg_pkg::ChargerOff));
    sample_q.push_back(make_sample(16'd3500, 16'd200, 16'd25, 1'b1, ChargerUnknown));
    sample_q.push_back(make_sample(16'd3600, 16'd10, 16'd30, 1'b1, ChargerUndefined));
    sample_q.push_back(make_sample(16'd3700, 16'd10, 16'd30, 1'b0, ChargerUndefined));
    sample_q.push_back(make_sample(16'd3000, 16'd0, 16'd1, 1'b0, ChargerOn));
    sample_q.push_back(make_sample(16'd4200, 16'd1, 16'd999, 1'b0, ChargerUnknown));
    sample_q.push_back(make_sample(16'd2000, 16'd500, 16'd1000, 1'b0, abfg_pkg::ChargerOff));
    sample_q.push_back(make_sample(16'd4201, '1, 16'd1001, 1'b1, ChargerOn));
    sample_q.push_back(make_sample(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, ChargerUnknown));
    sample_q.push_back(make_sample(16'h5555, 16'hAAAA, 16'h5555, 1'b0, ChargerOn));
    sample_q.push_back(make_sample('0, '1, '1, 1'b0, ChargerUndefined));
    sample_q.push_back(make_sample(16'd2999, 16'd7, 16'd7, 1'b1, abfg_pkg::ChargerOff));
    drain();

    // zero scales fall back to 1000; widest window
    program_gauge(25'd0, 25'd0, 25'd0, '1, 25'd0, '1, 25'd0);
    run_random(RandomPerSetting);
    // window under 1 mV truncates to zero millivolts, full scales: divide fault
    program_gauge(25'h00FFFF, 25'h00FFFF, 25'h00FFFF, 25'd1999, 25'd1000, '1, 25'd0);
    run_random(RandomPerSetting);
    // 1 mV window, charge span negative: negative saturation
    program_gauge(25'd1000, 25'd1, 25'd1, 25'd3001500, 25'd3000000, 25'd0, '1);
    run_random(RandomPerSetting);
    // window upside down
    program_gauge(25'd1000, 25'd250, 25'd2000, 25'd3000000, 25'd4200000, 25'd1000000,
                  25'd3000000);
    run_random(RandomPerSetting);
    // nonzero registers that still give a zero window in millivolts
    program_gauge(25'd1000, 25'd1000, 25'd1000, 25'd3700999, 25'd3700000, 25'd2500000,
                  25'd100000);
    run_random(RandomPerSetting);
    repeat (3) begin
      program_gauge(abfg_pkg::CfgDataW'($urandom), abfg_pkg::CfgDataW'($urandom),
                    abfg_pkg::CfgDataW'($urandom), abfg_pkg::CfgDataW'($urandom),
                    abfg_pkg::CfgDataW'($urandom), abfg_pkg::CfgDataW'($urandom),
                    abfg_pkg::CfgDataW'($urandom));
      run_random(RandomPerSetting);
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d requests (%0d invalid sets) over %0d register settings",
             samples_sent, invalid_sets, settings_cnt);
    $display("%0d divide faults, %0d saturated charges, %0d long receiver hold-offs",
             fault_cnt, sat_cnt, holds_done);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", readings_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
